>>> design/vtss_pkg.sv
`default_nettype none
package vtss_pkg;

    localparam int ENTRIES_DEF  = 512;
    localparam int MAX_DIM_DEF  = 16;
    localparam int ID_W         = 9;
    localparam int IDX_W        = 4;
    localparam int VAL_W        = 32;
    localparam int DIM_W        = 5;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 16;

    typedef enum logic [2:0] {
        F_ADD_USER = 3'd0,
        F_ADD_ITEM = 3'd1,
        F_DEL_USER = 3'd2,
        F_DEL_ITEM = 3'd3,
        F_RECOMMEND = 3'd4,
        F_FIND = 3'd5,
        F_MATRIX = 3'd6
    } t_func;

endpackage
`default_nettype wire

>>> design/vtss_ram.sv
`default_nettype none
module vtss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

>>> design/vector_table_similarity_search_core.sv
// An element word without last is staged while the block stays idle; the last word of an add,
// or a delete word, starts the table update. A new word is taken once the result is registered.
// Recommend and find-similar scan every slot, one multiply per element.
// Transform runs over the shared multiplier.
// One command is worked at a time; the result register frees the input side meanwhile.
// After reset the valid table is swept clear while no word is accepted.
`default_nettype none
module vector_table_similarity_search_core #(
    parameter int ENTRIES = vtss_pkg::ENTRIES_DEF,
    parameter int MAX_DIM = vtss_pkg::MAX_DIM_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [vtss_pkg::DIM_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // id[8:0], row[12:9], col[16:13], value[48:17], zero fill above
    input  wire logic [vtss_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // func[2:0]
    input  wire logic [2:0]                         i_s_tuser,
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // status[0], answer_id[9:1], zero fill above
    output logic [vtss_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    // answer_valid[0]
    output logic                                    o_m_tuser
);
    import vtss_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int ICW = $clog2(ENTRIES + 1);
    localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DCW = $clog2(MAX_DIM + 1);
    localparam int TD  = ENTRIES * MAX_DIM;
    localparam int TAW = $clog2(TD);
    localparam int MD2 = MAX_DIM * MAX_DIM;
    localparam int MAW = (MD2 > 1) ? $clog2(MD2) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_VRD, S_VCHK, S_COMMIT, S_VWR, S_LOADQ,
        S_SCAN_RD, S_SCAN_CHK, S_DOT, S_CMP, S_TWR, S_EMIT
    } t_state;

    t_state             r_state;
    logic [DIM_W-1:0]   r_dim;
    t_func              r_func;
    logic [ID_W-1:0]    r_id;
    logic               r_tr;
    logic [ICW-1:0]     r_i;
    logic [DCW-1:0]     r_j;
    logic [DCW-1:0]     r_r;
    logic [DW-1:0]      r_j1;
    logic               r_v1;
    logic               r_v2;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        r_bacc;
    logic               r_found;
    logic [IW-1:0]      r_best;
    logic [1:0]         r_vbits;
    logic               r_estat;
    logic               r_eav;
    logic [ID_W-1:0]    r_eid;
    logic               r_ovalid;
    logic               r_ostat;
    logic               r_oav;
    logic [ID_W-1:0]    r_oid;
    logic [VAL_W-1:0]   r_stage [MAX_DIM];
    logic [VAL_W-1:0]   r_q [MAX_DIM];

    // Input unpacking
    t_func              w_func;
    logic [ID_W-1:0]    w_id;
    logic [IDX_W-1:0]   w_row;
    logic [IDX_W-1:0]   w_col;
    logic [VAL_W-1:0]   w_value;
    logic               w_acc_in;
    logic               w_in_id_ok;
    logic               w_col_ok;
    logic               w_row_ok;

    assign w_func   = t_func'(i_s_tuser);
    assign w_id     = i_s_tdata[8:0];
    assign w_row    = i_s_tdata[12:9];
    assign w_col    = i_s_tdata[16:13];
    assign w_value  = i_s_tdata[48:17];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc_in = i_s_tvalid && o_s_tready;
    assign w_in_id_ok = 32'(w_id) < 32'(ENTRIES);
    assign w_col_ok = 32'(w_col) < 32'(MAX_DIM);
    assign w_row_ok = 32'(w_row) < 32'(MAX_DIM);

    // Dimension in use, clamped to 1..MAX_DIM
    logic [DCW-1:0] w_d;
    always_comb begin
        if (r_dim == '0) begin
            w_d = DCW'(1);
        end else if (32'(r_dim) > 32'(MAX_DIM)) begin
            w_d = DCW'(MAX_DIM);
        end else begin
            w_d = DCW'(r_dim);
        end
    end

    logic [IW-1:0] w_id_idx;
    assign w_id_idx = IW'(r_id);

    // Memory ports
    logic             w_v_we;
    logic [IW-1:0]    w_v_addr;
    logic [1:0]       w_v_wdata;
    logic [1:0]       w_v_rd;
    logic             w_u_we;
    logic             w_it_we;
    logic [TAW-1:0]   w_t_addr;
    logic [VAL_W-1:0] w_u_wdata;
    logic [VAL_W-1:0] w_u_rd;
    logic [VAL_W-1:0] w_it_rd;
    logic             w_m_we;
    logic [MAW-1:0]   w_m_addr;
    logic [VAL_W-1:0] w_m_rd;
    logic [IW-1:0]    w_slot;
    logic [DW-1:0]    w_elem;

    always_comb begin
        w_v_we = (r_state == S_CLR) || (r_state == S_VWR);
        w_v_addr = ((r_state == S_VRD) || (r_state == S_VWR)) ? w_id_idx : r_i[IW-1:0];
        case (r_func)
            F_ADD_USER: w_v_wdata = r_vbits | 2'b01;
            F_ADD_ITEM: w_v_wdata = r_vbits | 2'b10;
            F_DEL_USER: w_v_wdata = r_vbits & 2'b10;
            default:    w_v_wdata = r_vbits & 2'b01;
        endcase
        if (r_state == S_CLR) begin
            w_v_wdata = 2'b00;
        end

        w_slot = ((r_state == S_COMMIT) || ((r_state == S_LOADQ) && !r_tr))
                 ? w_id_idx : r_i[IW-1:0];
        w_elem = (r_state == S_TWR) ? r_r[DW-1:0] : r_j[DW-1:0];
        w_t_addr = TAW'(w_slot) * TAW'(MAX_DIM) + TAW'(w_elem);
        w_u_we = ((r_state == S_COMMIT) && (r_func == F_ADD_USER)) || (r_state == S_TWR);
        w_it_we = (r_state == S_COMMIT) && (r_func == F_ADD_ITEM);
        w_u_wdata = (r_state == S_COMMIT) ? r_stage[r_j[DW-1:0]] : r_acc[31:0];

        w_m_we = w_acc_in && (w_func == F_MATRIX) && w_row_ok && w_col_ok;
        if (r_state == S_IDLE) begin
            w_m_addr = MAW'(DW'(w_row)) * MAW'(MAX_DIM) + MAW'(DW'(w_col));
        end else begin
            w_m_addr = MAW'(r_r[DW-1:0]) * MAW'(MAX_DIM) + MAW'(r_j[DW-1:0]);
        end
    end

    vtss_ram #(.WIDTH(2), .DEPTH(ENTRIES), .AW(IW)) u_valid (
        .i_clk(i_clk), .i_we(w_v_we), .i_addr(w_v_addr), .i_wdata(w_v_wdata),
        .o_rdata(w_v_rd)
    );
    vtss_ram #(.WIDTH(VAL_W), .DEPTH(TD), .AW(TAW)) u_user (
        .i_clk(i_clk), .i_we(w_u_we), .i_addr(w_t_addr), .i_wdata(w_u_wdata),
        .o_rdata(w_u_rd)
    );
    vtss_ram #(.WIDTH(VAL_W), .DEPTH(TD), .AW(TAW)) u_item (
        .i_clk(i_clk), .i_we(w_it_we), .i_addr(w_t_addr), .i_wdata(w_u_wdata),
        .o_rdata(w_it_rd)
    );
    vtss_ram #(.WIDTH(VAL_W), .DEPTH(MD2), .AW(MAW)) u_matrix (
        .i_clk(i_clk), .i_we(w_m_we), .i_addr(w_m_addr), .i_wdata(w_value),
        .o_rdata(w_m_rd)
    );

    // Shared multiplier; find-similar squares the element difference.
    logic [VAL_W-1:0]  w_rd;
    logic [VAL_W-1:0]  w_qv;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [32:0] w_diff;
    logic signed [65:0] w_mul;

    always_comb begin
        if (r_tr) begin
            w_rd = w_m_rd;
        end else if (r_func == F_RECOMMEND) begin
            w_rd = w_it_rd;
        end else begin
            w_rd = w_u_rd;
        end
        w_qv = r_q[r_j1];
        w_diff = $signed({w_qv[31], w_qv}) - $signed({w_rd[31], w_rd});
        if (!r_tr && (r_func == F_FIND)) begin
            w_ma = w_diff;
            w_mb = w_diff;
        end else begin
            w_ma = $signed({w_rd[31], w_rd});
            w_mb = $signed({w_qv[31], w_qv});
        end
        w_mul = w_ma * w_mb;
    end

    logic w_better;
    logic w_elig;
    logic w_pipe_done;
    assign w_better = !r_found || ((r_func == F_RECOMMEND) ? ($signed(r_acc) > $signed(r_bacc))
                                                           : (r_acc < r_bacc));
    assign w_elig = r_tr ? w_v_rd[0]
                         : ((r_func == F_RECOMMEND) ? w_v_rd[1]
                                                    : (w_v_rd[0] && (r_i[IW-1:0] != w_id_idx)));
    assign w_pipe_done = (r_j == w_d) && !r_v1 && !r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_dim    <= DIM_W'(1);
            r_i      <= '0;
            r_ovalid <= 1'b0;
            r_tr     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
            if (i_m_tready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_i == ICW'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_i <= r_i + ICW'(1);
                end
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_func <= w_func;
                        r_id   <= w_id;
                        r_estat <= 1'b1;
                        r_eav  <= 1'b0;
                        r_eid  <= '0;
                        unique case (w_func)
                            F_ADD_USER, F_ADD_ITEM: begin
                                if (w_col_ok) begin
                                    r_stage[DW'(w_col)] <= w_value;
                                end
                                if (i_s_tlast) begin
                                    r_state <= w_in_id_ok ? S_VRD : S_EMIT;
                                end
                            end
                            F_DEL_USER, F_DEL_ITEM, F_RECOMMEND, F_FIND: begin
                                r_state <= w_in_id_ok ? S_VRD : S_EMIT;
                            end
                            F_MATRIX: begin
                                if (i_s_tlast) begin
                                    r_tr    <= 1'b1;
                                    r_i     <= '0;
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_VRD: begin
                    r_state <= S_VCHK;
                end
                S_VCHK: begin
                    r_vbits <= w_v_rd;
                    r_j     <= '0;
                    r_v1    <= 1'b0;
                    r_v2    <= 1'b0;
                    unique case (r_func)
                        F_ADD_USER: r_state <= w_v_rd[0] ? S_EMIT : S_COMMIT;
                        F_ADD_ITEM: r_state <= w_v_rd[1] ? S_EMIT : S_COMMIT;
                        F_DEL_USER: r_state <= w_v_rd[0] ? S_VWR : S_EMIT;
                        F_DEL_ITEM: r_state <= w_v_rd[1] ? S_VWR : S_EMIT;
                        F_RECOMMEND, F_FIND: begin
                            r_tr    <= 1'b0;
                            r_state <= w_v_rd[0] ? S_LOADQ : S_EMIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_COMMIT: begin
                    if (r_j == w_d - DCW'(1)) begin
                        r_state <= S_VWR;
                    end else begin
                        r_j <= r_j + DCW'(1);
                    end
                end
                S_VWR: begin
                    r_estat <= 1'b0;
                    r_state <= S_EMIT;
                end
                S_LOADQ: begin
                    if (r_j < w_d) begin
                        r_j  <= r_j + DCW'(1);
                        r_j1 <= r_j[DW-1:0];
                        r_v1 <= 1'b1;
                    end else begin
                        r_v1 <= 1'b0;
                    end
                    if (r_v1) begin
                        r_q[r_j1] <= w_u_rd;
                    end
                    if ((r_j == w_d) && !r_v1) begin
                        r_j   <= '0;
                        r_v2  <= 1'b0;
                        r_acc <= '0;
                        r_r   <= '0;
                        if (r_tr) begin
                            r_state <= S_DOT;
                        end else begin
                            r_i     <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (r_i == ICW'(ENTRIES)) begin
                        if (r_tr) begin
                            r_estat <= 1'b0;
                        end else if (r_found) begin
                            r_estat <= 1'b0;
                            r_eav   <= 1'b1;
                            r_eid   <= ID_W'(r_best);
                        end
                        r_tr    <= 1'b0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    r_j   <= '0;
                    r_v1  <= 1'b0;
                    r_v2  <= 1'b0;
                    r_acc <= '0;
                    if (w_elig) begin
                        r_state <= r_tr ? S_LOADQ : S_DOT;
                    end else begin
                        r_i     <= r_i + ICW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DOT: begin
                    if (r_j < w_d) begin
                        r_j  <= r_j + DCW'(1);
                        r_j1 <= r_j[DW-1:0];
                        r_v1 <= 1'b1;
                    end else begin
                        r_v1 <= 1'b0;
                    end
                    if (r_v1) begin
                        r_prod <= w_mul[63:0];
                    end
                    r_v2 <= r_v1;
                    if (r_v2) begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (w_pipe_done) begin
                        r_state <= r_tr ? S_TWR : S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_better) begin
                        r_found <= 1'b1;
                        r_bacc  <= r_acc;
                        r_best  <= r_i[IW-1:0];
                    end
                    r_i     <= r_i + ICW'(1);
                    r_state <= S_SCAN_RD;
                end
                S_TWR: begin
                    r_j   <= '0;
                    r_v1  <= 1'b0;
                    r_v2  <= 1'b0;
                    r_acc <= '0;
                    if (r_r == w_d - DCW'(1)) begin
                        r_i     <= r_i + ICW'(1);
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_r     <= r_r + DCW'(1);
                        r_state <= S_DOT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= r_estat;
                        r_oav    <= r_eav;
                        r_oid    <= r_eid;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_oid, r_ostat};
    assign o_m_tuser  = r_oav;

endmodule
`default_nettype wire

>>> design/vtss_checker.sv
`default_nettype none
module vtss_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [vtss_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                            o_m_tuser
);

    // Reset drops any pending word.
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output word survives reset");

    // The valid table is being swept right after reset.
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_tready)
        else $error("input ready during clearing pass");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output word changed");

    // A search answer always comes with an ok status.
    a_ans_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> !o_m_tdata[0])
        else $error("answer flagged with error status");

    a_ans_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[9:1] == 9'd0))
        else $error("answer id set without a search result");

endmodule

bind vector_table_similarity_search_core vtss_checker u_vtss_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata),
    .o_m_tuser(o_m_tuser)
);
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import vtss_pkg::*;

    localparam int NSLOT = ENTRIES_DEF;
    localparam int MDIM = MAX_DIM_DEF;
    localparam logic [2:0] F_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  func;
        logic [8:0]  id;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } t_cmd;

    typedef struct {
        logic       status;
        logic [8:0] answer_id;
        logic       answer_valid;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tready = 1'b0;
    logic o_s_tready;
    logic o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic o_m_tuser;

    vector_table_similarity_search_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Commands waiting to be sent, and answers the block still owes.
    t_cmd  cmd_q[$];
    t_resp answer_q[$];
    t_cmd  cur_cmd;
    int    errs = 0;
    bit    quiet = 1'b0;
    int    src_gap = 0;
    int    snk_gap = 0;
    int    hold_left = 0;
    logic  hold_start = 1'b0;

    // Shadow of the block's tables.
    logic [31:0] m_user [0:NSLOT*MDIM-1];
    logic [31:0] m_item [0:NSLOT*MDIM-1];
    bit          m_uval [0:NSLOT-1];
    bit          m_ival [0:NSLOT-1];
    logic [31:0] m_stage [0:MDIM-1];
    logic [31:0] m_mat [0:MDIM*MDIM-1];
    logic [4:0]  m_dim = 5'd1;

    // Slot occupancy as the stimulus generator expects it to be.
    bit g_uval [0:NSLOT-1];
    bit g_ival [0:NSLOT-1];
    int g_dim = 1;

    function automatic int eff_dim(logic [4:0] v);
        if (v == 0) return 1;
        if (v > MDIM) return MDIM;
        return int'(v);
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    task automatic owe(logic st, logic [8:0] aid, logic av);
        t_resp r;
        r.status = st;
        r.answer_id = aid;
        r.answer_valid = av;
        answer_q.push_back(r);
    endtask

    task automatic model_command(t_cmd c);
        int d;
        bit found;
        longint acc;
        longint best;
        longint diff;
        bit [63:0] sq_dist;
        bit [63:0] best_dist;
        int best_id;
        logic [31:0] tmp [0:MDIM-1];
        d = eff_dim(m_dim);
        case (c.func)
            F_ADD_USER, F_ADD_ITEM: begin
                m_stage[c.col] = c.value;
                if (c.last) begin
                    if (c.func == F_ADD_USER ? m_uval[c.id] : m_ival[c.id]) begin
                        owe(1'b1, '0, 1'b0);
                    end else begin
                        for (int j = 0; j < d; j++) begin
                            if (c.func == F_ADD_USER) m_user[c.id*MDIM+j] = m_stage[j];
                            else m_item[c.id*MDIM+j] = m_stage[j];
                        end
                        if (c.func == F_ADD_USER) m_uval[c.id] = 1'b1;
                        else m_ival[c.id] = 1'b1;
                        owe(1'b0, '0, 1'b0);
                    end
                end
            end
            F_DEL_USER, F_DEL_ITEM: begin
                if (c.func == F_DEL_USER ? !m_uval[c.id] : !m_ival[c.id]) begin
                    owe(1'b1, '0, 1'b0);
                end else begin
                    if (c.func == F_DEL_USER) m_uval[c.id] = 1'b0;
                    else m_ival[c.id] = 1'b0;
                    owe(1'b0, '0, 1'b0);
                end
            end
            F_RECOMMEND: begin
                found = 1'b0;
                best = 0;
                best_id = 0;
                if (m_uval[c.id]) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (m_ival[i]) begin
                            acc = 0;
                            for (int j = 0; j < d; j++)
                                acc += sx(m_user[c.id*MDIM+j]) * sx(m_item[i*MDIM+j]);
                            if (!found || acc > best) begin
                                found = 1'b1;
                                best = acc;
                                best_id = i;
                            end
                        end
                    end
                end
                if (found) owe(1'b0, best_id[8:0], 1'b1);
                else owe(1'b1, '0, 1'b0);
            end
            F_FIND: begin
                found = 1'b0;
                best_dist = 0;
                best_id = 0;
                if (m_uval[c.id]) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (m_uval[i] && i != c.id) begin
                            sq_dist = 0;
                            for (int j = 0; j < d; j++) begin
                                diff = sx(m_user[c.id*MDIM+j]) - sx(m_user[i*MDIM+j]);
                                sq_dist += diff * diff;
                            end
                            if (!found || sq_dist < best_dist) begin
                                found = 1'b1;
                                best_dist = sq_dist;
                                best_id = i;
                            end
                        end
                    end
                end
                if (found) owe(1'b0, best_id[8:0], 1'b1);
                else owe(1'b1, '0, 1'b0);
            end
            F_MATRIX: begin
                m_mat[c.row*MDIM+c.col] = c.value;
                if (c.last) begin
                    for (int u = 0; u < NSLOT; u++) begin
                        if (m_uval[u]) begin
                            for (int r = 0; r < d; r++) begin
                                acc = 0;
                                for (int k = 0; k < d; k++)
                                    acc += sx(m_mat[r*MDIM+k]) * sx(m_user[u*MDIM+k]);
                                tmp[r] = acc[31:0];
                            end
                            for (int r = 0; r < d; r++) m_user[u*MDIM+r] = tmp[r];
                        end
                    end
                    owe(1'b0, '0, 1'b0);
                end
            end
            default: ;
        endcase
    endtask

    // Input side driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) model_command(cur_cmd);
            if (!s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    src_gap = $urandom_range(0, 12);
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, cur_cmd.value, cur_cmd.col, cur_cmd.row, cur_cmd.id};
                    s_tuser <= cur_cmd.func;
                    s_tlast <= cur_cmd.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_start) hold_left <= 3000;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // Output side: check each word and pace tready.
    always @(posedge i_clk) begin
        t_resp exp_r;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    if (errs < 10) $display("unexpected result word %h/%b", o_m_tdata, o_m_tuser);
                    errs++;
                end else begin
                    exp_r = answer_q.pop_front();
                    if (o_m_tdata[0] !== exp_r.status || o_m_tdata[9:1] !== exp_r.answer_id
                        || o_m_tuser !== exp_r.answer_valid) begin
                        if (errs < 10)
                            $display("mismatch: exp st=%b id=%0d av=%b, got st=%b id=%0d av=%b",
                                     exp_r.status, exp_r.answer_id, exp_r.answer_valid,
                                     o_m_tdata[0], o_m_tdata[9:1], o_m_tuser);
                        errs++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(logic [2:0] f, int id, int row, int col, logic [31:0] v, bit lst);
        t_cmd c;
        c.func = f;
        c.id = id[8:0];
        c.row = row[3:0];
        c.col = col[3:0];
        c.value = v;
        c.last = lst;
        cmd_q.push_back(c);
        if (lst && f == F_ADD_USER) g_uval[id] = 1'b1;
        if (lst && f == F_ADD_ITEM) g_ival[id] = 1'b1;
        if (f == F_DEL_USER) g_uval[id] = 1'b0;
        if (f == F_DEL_ITEM) g_ival[id] = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_id();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, NSLOT - 1);
        return $urandom_range(0, 7);
    endfunction

    task automatic random_command();
        int sel;
        int id;
        logic [2:0] f;
        sel = $urandom_range(0, 99);
        id = pick_id();
        if (sel < 35) begin
            f = $urandom_range(0, 1) ? F_ADD_USER : F_ADD_ITEM;
            if ($urandom_range(0, 1)) begin
                for (int j = 0; j < g_dim; j++)
                    send(f, id, $urandom_range(0, 15), j, pick_value(), j == g_dim - 1);
            end else begin
                send(f, id, $urandom_range(0, 15), $urandom_range(0, 15), pick_value(), 1'b1);
            end
        end else if (sel < 50) begin
            send($urandom_range(0, 1) ? F_DEL_USER : F_DEL_ITEM, id,
                 $urandom_range(0, 15), $urandom_range(0, 15), $urandom, 1'b0);
        end else if (sel < 75) begin
            send($urandom_range(0, 1) ? F_RECOMMEND : F_FIND, id,
                 $urandom_range(0, 15), $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
        end else if (sel < 82 && g_dim <= 4) begin
            // Fill the whole active block of the matrix before the word that starts the transform.
            for (int r = 0; r < g_dim; r++)
                for (int k = 0; k < g_dim; k++)
                    send(F_MATRIX, $urandom, r, k, pick_value(),
                         r == g_dim - 1 && k == g_dim - 1);
        end else if (sel < 90) begin
            send($urandom_range(0, 1) ? F_ADD_USER : F_ADD_ITEM, id,
                 $urandom_range(0, 15), $urandom_range(0, 15), pick_value(), 1'b0);
        end else if (sel < 94) begin
            send(F_UNUSED, $urandom, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom, $urandom_range(0, 1));
        end else begin
            // Matrix entries with no closing word leave the transform pending.
            send(F_MATRIX, $urandom, $urandom_range(0, 15), $urandom_range(0, 15),
                 pick_value(), 1'b0);
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (!(cmd_q.size() == 0 && !s_tvalid && answer_q.size() == 0));
        repeat (200) @(negedge i_clk);
    endtask

    task automatic change_dim(logic [4:0] v);
        // Stored vectors are shorter than a larger dim, so empty the tables first.
        if (eff_dim(v) > g_dim) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (g_uval[i]) send(F_DEL_USER, i, 0, 0, 32'h0, 1'b0);
                if (g_ival[i]) send(F_DEL_ITEM, i, 0, 0, 32'h0, 1'b0);
            end
            drain();
        end
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        m_dim = v;
        g_dim = eff_dim(v);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every staging element once so later commits never read stale lanes.
        for (int j = 0; j < MDIM; j++)
            send(F_ADD_USER, 0, j, j, j < 4 ? pick_value() : $urandom, 1'b0);
        send(F_RECOMMEND, 0, 0, 0, 32'h0, 1'b0);
        send(F_FIND, 0, 0, 0, 32'h0, 1'b0);
        send(F_DEL_USER, 0, 0, 0, 32'h0, 1'b0);
        send(F_DEL_ITEM, 5, 0, 0, 32'h0, 1'b0);
        send(F_ADD_USER, 0, 0, 0, 32'h7fff_ffff, 1'b1);
        send(F_ADD_USER, 0, 0, 0, 32'h1, 1'b1);
        send(F_RECOMMEND, 0, 0, 0, 32'h0, 1'b0);
        send(F_FIND, 0, 0, 0, 32'h0, 1'b0);
        send(F_ADD_ITEM, 511, 15, 0, 32'h8000_0000, 1'b1);
        send(F_ADD_ITEM, 3, 0, 0, 32'h8000_0000, 1'b1);
        send(F_RECOMMEND, 0, 0, 0, 32'h0, 1'b1);
        send(F_ADD_USER, 1, 0, 0, 32'hffff_ffff, 1'b1);
        send(F_FIND, 0, 0, 0, 32'h0, 1'b0);
        send(F_MATRIX, 0, 0, 0, 32'hffff_ffff, 1'b1);
        send(F_UNUSED, 511, 15, 15, 32'hffff_ffff, 1'b1);
        send(F_DEL_ITEM, 3, 0, 0, 32'h0, 1'b0);
        send(F_RECOMMEND, 1, 0, 0, 32'h0, 1'b0);
        drain();

        change_dim(5'd3);
        // Hold the output side off while words keep coming, so the block backs up.
        @(posedge i_clk);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        repeat (6) random_command();
        drain();

        change_dim(5'd16);
        repeat (4) random_command();
        drain();
        change_dim(5'd2);
        repeat (6) random_command();
        drain();
        change_dim(5'd31);
        repeat (3) random_command();
        drain();
        change_dim(5'd0);
        repeat (6) random_command();
        drain();
        change_dim(5'd5);
        repeat (5) random_command();
        drain();
        change_dim(5'd1);
        quiet = 1'b1;
        repeat (6) random_command();
        drain();

        if (errs == 0 && answer_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
design/vtss_pkg.sv
design/vtss_ram.sv
design/vector_table_similarity_search_core.sv
design/vtss_checker.sv
tb/testbench.sv
